FILE: hw/rtl/rq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rq_pkg: shared types and constants
// Word formats, mode and status codes, and controller/datapath command structs.
// ----------------------------------------------------------------------------
package rq_pkg;

  localparam int QueueDepth = 16;
  localparam int SlotBits   = 4;
  localparam int CountBits  = 5;
  localparam int AddrBits   = 10;
  localparam int KeyBits    = 10;
  localparam int IdBits     = 8;
  localparam int EntryBits  = IdBits + 2 * AddrBits + 2 * KeyBits;

  localparam logic [2:0] MODE_TAIL  = 3'd0;
  localparam logic [2:0] MODE_HEAD  = 3'd1;
  localparam logic [2:0] MODE_SJF   = 3'd2;
  localparam logic [2:0] MODE_AGING = 3'd3;
  localparam logic [2:0] MODE_DEQ   = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]          mode;
    logic [IdBits-1:0]   proc_id;
    logic [AddrBits-1:0] start_addr;
    logic [AddrBits-1:0] pc_value;
    logic [KeyBits-1:0]  prog_len;
    logic [KeyBits-1:0]  score;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 out_valid;
    logic [IdBits-1:0]    out_proc_id;
    logic [AddrBits-1:0]  out_start_addr;
    logic [AddrBits-1:0]  out_pc_value;
    logic [KeyBits-1:0]   out_prog_len;
    logic [KeyBits-1:0]   out_score;
    logic [CountBits-1:0] occupancy;
  } out_word_t;

  typedef struct packed {
    logic [IdBits-1:0]   id;
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] pc;
    logic [KeyBits-1:0]  len;
    logic [KeyBits-1:0]  score;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic walk_start; // point walker at head, read it
    logic walk_step;  // advance walker by one link
    logic rd_head;    // read the head entry
    logic place;      // link the new entry at pos
    logic use_zero;   // place at position zero
    logic use_tail;   // place at tail
    logic deq;        // unlink head
    logic emit;       // load output register
    logic [1:0] status;
    logic forget;     // clear last-head known
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       empty;
    logic       walk_done; // walker reached end or a larger key
    logic       keep_head; // aging keep condition
    logic       out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rq_ram: generic single-port-write, single-port-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module rq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rq_datapath: queue storage, link walker and output register
// Entries sit in a RAM; links are kept in flops for the walk.
// ----------------------------------------------------------------------------
module rq_datapath import rq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_word_t  in_word,
  input  wire dp_cmd_t   cmd,
  output dp_sts_t        sts,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);
  in_word_t              cur_r;
  logic [SlotBits-1:0]   link_r [QueueDepth];
  logic [SlotBits-1:0]   free_r [QueueDepth];
  logic [SlotBits-1:0]   head_r, tail_r, walk_r, prev_r;
  logic [CountBits-1:0]  cnt_r, pos_r;
  logic [IdBits-1:0]     last_id_r;
  logic                  last_known_r;
  logic                  out_valid_r;
  out_word_t             out_r;

  logic                  ram_we;
  logic [SlotBits-1:0]   ram_raddr, new_slot;
  entry_t                ram_rd, new_e;
  logic [KeyBits-1:0]    rd_key, new_key;

  assign new_slot = free_r[SlotBits'(QueueDepth - 1) - cnt_r[SlotBits-1:0]];
  assign new_e    = '{cur_r.proc_id, cur_r.start_addr, cur_r.pc_value,
                      cur_r.prog_len, cur_r.score};
  assign ram_we   = cmd.place;

  always_comb begin
    ram_raddr = walk_r;
    if (cmd.walk_start || cmd.rd_head) ram_raddr = head_r;
    else if (cmd.walk_step) ram_raddr = link_r[walk_r];
  end

  rq_ram #(.Width(EntryBits), .Depth(QueueDepth)) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (new_slot),
    .wdata (new_e),
    .raddr (ram_raddr),
    .rdata (ram_rd)
  );

  // sort key of the entry under the walker
  assign rd_key  = (cur_r.mode == MODE_AGING) ? ram_rd.score : ram_rd.len;
  assign new_key = (cur_r.mode == MODE_AGING) ? cur_r.score : cur_r.prog_len;

  assign sts.mode      = cur_r.mode;
  assign sts.full      = cnt_r == CountBits'(QueueDepth);
  assign sts.empty     = cnt_r == '0;
  assign sts.walk_done = (pos_r == cnt_r) || (rd_key > new_key);
  assign sts.keep_head = last_known_r && (cur_r.proc_id == last_id_r) &&
                         ((cnt_r == '0) || (ram_rd.score >= cur_r.score));
  assign sts.out_busy  = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QueueDepth; i++) free_r[i] <= SlotBits'(QueueDepth - 1 - i);
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      last_id_r    <= '0;
      last_known_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) cur_r <= in_word;
      if (cmd.walk_start) begin
        walk_r <= head_r;
        prev_r <= head_r;
        pos_r  <= '0;
      end
      if (cmd.walk_step) begin
        prev_r <= walk_r;
        walk_r <= link_r[walk_r];
        pos_r  <= pos_r + 1'b1;
      end
      if (cmd.place) begin
        // an empty queue always takes the new entry as its head
        if (cmd.use_zero || cnt_r == '0 || (!cmd.use_tail && pos_r == '0)) begin
          link_r[new_slot] <= head_r;
          head_r           <= new_slot;
        end else if (cmd.use_tail) begin
          link_r[tail_r]   <= new_slot;
        end else begin
          link_r[new_slot] <= link_r[prev_r];
          link_r[prev_r]   <= new_slot;
        end
        if (cmd.use_tail || (!cmd.use_zero && pos_r == cnt_r) || cnt_r == '0)
          tail_r <= new_slot;
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.forget) last_known_r <= 1'b0;
      if (cmd.deq) begin
        last_id_r    <= ram_rd.id;
        last_known_r <= 1'b1;
        free_r[SlotBits'(QueueDepth) - cnt_r[SlotBits-1:0]] <= head_r;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CountBits'(1)) begin
          head_r <= '0;
          tail_r <= '0;
        end else begin
          head_r <= link_r[head_r];
        end
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // output word, occupancy taken after this operation
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status    <= cmd.status;
      out_r.out_valid <= cmd.deq;
      out_r.out_proc_id    <= cmd.deq ? ram_rd.id    : '0;
      out_r.out_start_addr <= cmd.deq ? ram_rd.start : '0;
      out_r.out_pc_value   <= cmd.deq ? ram_rd.pc    : '0;
      out_r.out_prog_len   <= cmd.deq ? ram_rd.len   : '0;
      out_r.out_score      <= cmd.deq ? ram_rd.score : '0;
      out_r.occupancy <= cmd.place ? cnt_r + 1'b1 : (cmd.deq ? cnt_r - 1'b1 : cnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;
endmodule
`default_nettype wire

FILE: hw/rtl/rq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rq_ctrl: operation sequencer
// Decodes the mode and steps the datapath through read, walk and link.
// ----------------------------------------------------------------------------
module rq_ctrl import rq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && !sts.out_busy;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.mode == MODE_DEQ) begin
          if (sts.empty) begin
            cmd.emit   = 1'b1;
            cmd.status = STATUS_EMPTY;
            state_nxt  = S_IDLE;
          end else begin
            cmd.rd_head = 1'b1;
            state_nxt   = S_HEAD;
          end
        end else if (sts.mode > MODE_DEQ) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.full) begin
          cmd.emit   = 1'b1;
          cmd.status = STATUS_FULL;
          state_nxt  = S_IDLE;
        end else if (sts.mode == MODE_TAIL || sts.mode == MODE_HEAD) begin
          cmd.place    = 1'b1;
          cmd.use_tail = sts.mode == MODE_TAIL;
          cmd.use_zero = sts.mode == MODE_HEAD;
          cmd.forget   = sts.mode == MODE_HEAD;
          cmd.emit     = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_WAIT;
        end
      end
      S_HEAD: begin
        cmd.deq   = 1'b1;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_WAIT: begin
        // head entry now readable; aging may place the new entry at the front
        if (sts.mode == MODE_AGING && sts.keep_head) begin
          cmd.place    = 1'b1;
          cmd.use_zero = 1'b1;
          cmd.forget   = 1'b1;
          cmd.emit     = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_WALK;
          if (sts.walk_done) begin
            cmd.place  = 1'b1;
            cmd.emit   = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.walk_step = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (sts.walk_done) begin
          cmd.place = 1'b1;
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // aging insert landing at the front also forgets
    if (cmd.place && !cmd.use_tail && !cmd.use_zero && sts.mode == MODE_AGING &&
        state_r == S_WAIT)
      cmd.forget = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ready_queue_fifo_sjf_aging.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ready_queue_fifo_sjf_aging: bounded process ready queue
// Tail/head push, shortest-first and aging sorted insert, dequeue.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one request word (mode plus entry).
//   out_valid/out_ready/out_data return exactly one result word per request.
//   Tail, head, full, empty and unused modes: the result is loaded from the
//   decode state. Dequeue first reads the head entry from the entry RAM.
//   Sorted inserts walk the list one entry per cycle from the head.
//   One request is worked at a time; in_ready is low while a request is in
//   flight or the result register is still full, so no new request is taken
//   until the last result word has been taken.
//   A stalled receiver holds the result word; no new request is taken.
//   Reset (rst_n low, synchronous) empties the queue, refills the free slot
//   stack and forgets the last dequeued id; entry RAM contents are kept.
// ----------------------------------------------------------------------------
module ready_queue_fifo_sjf_aging import rq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  rq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rq_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_data)
  );
endmodule
`default_nettype wire
